// ----- hdl/lob_pkg.sv -----
// lob_pkg: shared types and constants for the limit order book.
// No dependencies.
`default_nettype none
package lob_pkg;
	localparam int ORDER_CAPACITY = 64;
	localparam int SLOT_BITS = $clog2(ORDER_CAPACITY);
	localparam int CNT_BITS = $clog2(ORDER_CAPACITY + 1);
	localparam int PRICE_BITS = 32;

	localparam logic [2:0] KIND_ADD    = 3'd0;
	localparam logic [2:0] KIND_CANCEL = 3'd1;
	localparam logic [2:0] KIND_MODIFY = 3'd2;
	localparam logic [2:0] KIND_LIST   = 3'd3;
	localparam logic [2:0] KIND_EXISTS = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNKNOWN   = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_UNCHANGED = 3'd4;

	// one slot as held in the order memory
	typedef struct packed {
		logic [63:0]           order_id;
		logic [PRICE_BITS-1:0] price;
		logic [31:0]           quantity;
		logic                  side;
		logic [SLOT_BITS-1:0]  arrival;
	} slot_t;
endpackage
`default_nettype wire

// ----- hdl/limit_order_book.sv -----
// limit_order_book: price-time priority order book, one slot memory swept by a
// sequencer. Depends on lob_pkg.
// Sequence: add, exists, unknown ids, unchanged and in-place modify take two scans of
// ORDER_CAPACITY slots (find, then best price); cancel adds a gap-closing scan and a
// re-placing modify one more write after it. A list runs a best-price scan, then one
// scan per live rank, and gives one result per member (an empty level gives one marker).
// busy is high for the whole transaction; one slot memory read port sets the pace.
// Results appear for one cycle with result_valid; the receiver cannot stall.
// Reset clears all valid bits, the live count and the sequencer; no clearing pass.
`default_nettype none
module limit_order_book (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         kind,
	input  wire logic [63:0]        order_id,
	input  wire logic [31:0]        price,
	input  wire logic [31:0]        quantity,
	input  wire logic               side,
	output logic                    result_valid,
	output logic [2:0]              status,
	output logic signed [32:0]      best_bid,
	output logic signed [32:0]      best_ask,
	output logic                    has_id,
	output logic [63:0]             listed_id,
	output logic                    last
);
	localparam int SB = lob_pkg::SLOT_BITS;
	localparam int CB = lob_pkg::CNT_BITS;
	localparam int PB = lob_pkg::PRICE_BITS;
	// internal kind marker: best-price scan of a list is done
	localparam logic [2:0] KIND_BEST_DONE = 3'd7;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FIND  = 7'b0000010, // scan 1: id match and first free slot
		S_ACT   = 7'b0000100, // decide, write slot
		S_SHIFT = 7'b0001000, // scan 2: close arrival gap after removal
		S_PLACE = 7'b0010000, // write re-added order
		S_BEST  = 7'b0100000, // scan 3: best bid / ask
		S_LIST  = 7'b1000000  // list scan: one rank per pass
	} state_t;

	state_t state_q;
	// transaction registers
	logic [2:0]        kind_q;
	logic [63:0]       id_q;
	logic [PB-1:0]     px_q;
	logic [31:0]       qty_q;
	logic              side_q;
	logic [2:0]        status_q;
	// slot memory: valid bits in flops, payload in a memory
	logic [lob_pkg::ORDER_CAPACITY-1:0] valid_q;
	lob_pkg::slot_t    mem [lob_pkg::ORDER_CAPACITY];
	lob_pkg::slot_t    rd_q;
	logic [CB-1:0]     live_q;
	// scan control: idx_q is the address read this cycle, data arrives next cycle
	logic [CB-1:0]     idx_q;
	logic [SB-1:0]     rd_idx_q;
	logic              rd_ok_q;
	logic              hit_q, free_ok_q;
	logic [SB-1:0]     hit_slot_q, free_slot_q;
	lob_pkg::slot_t    hit_data_q;
	logic [SB-1:0]     gap_q;       // arrival rank that was removed
	logic              hb_q, ha_q;
	logic [PB-1:0]     b_q, a_q;
	logic [CB-1:0]     rank_q;      // list: rank being searched
	logic              pend_q;      // list: a member is held for output
	logic [63:0]       pend_id_q;

	// memory write port
	logic              we;
	logic [SB-1:0]     wa;
	lob_pkg::slot_t    wd;

	wire logic scan_end = (idx_q == CB'(lob_pkg::ORDER_CAPACITY));
	wire logic rd_valid = rd_ok_q && valid_q[rd_idx_q];

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[idx_q[SB-1:0]];
	end

	// place helper values
	lob_pkg::slot_t new_slot;
	always_comb begin
		new_slot.order_id = id_q;
		new_slot.price    = px_q;
		new_slot.quantity = qty_q;
		new_slot.side     = side_q;
		new_slot.arrival  = live_q[SB-1:0];
	end

	always_comb begin
		we = 1'b0;
		wa = rd_idx_q;
		wd = rd_q;
		unique case (state_q)
			S_ACT: begin
				if (kind_q == lob_pkg::KIND_ADD && !hit_q && free_ok_q) begin
					we = 1'b1;
					wa = free_slot_q;
					wd = new_slot;
				end else if (kind_q == lob_pkg::KIND_MODIFY && hit_q &&
						hit_data_q.price == px_q && hit_data_q.side == side_q &&
						hit_data_q.quantity < qty_q) begin
					we = 1'b1;
					wa = hit_slot_q;
					wd = hit_data_q;
					wd.quantity = qty_q;
				end
			end
			S_SHIFT: begin
				if (rd_valid && rd_q.arrival > gap_q) begin
					we = 1'b1;
					wd.arrival = rd_q.arrival - SB'(1);
				end
			end
			S_PLACE: begin
				we = 1'b1;
				wa = hit_slot_q;
				wd = new_slot;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			live_q       <= '0;
			idx_q        <= '0;
			rd_ok_q      <= 1'b0;
			result_valid <= 1'b0;
			pend_q       <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			rd_ok_q      <= 1'b0;
			rd_idx_q     <= idx_q[SB-1:0];
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q    <= kind;
						id_q      <= order_id;
						px_q      <= price[PB-1:0];
						qty_q     <= quantity;
						side_q    <= side;
						status_q  <= lob_pkg::ST_OK;
						hit_q     <= 1'b0;
						free_ok_q <= 1'b0;
						idx_q     <= '0;
						rank_q    <= '0;
						pend_q    <= 1'b0;
						hb_q      <= 1'b0;
						ha_q      <= 1'b0;
						state_q   <= (kind == lob_pkg::KIND_LIST) ? S_LIST : S_FIND;
					end
				end
				S_FIND: begin
					if (!scan_end) begin
						idx_q   <= idx_q + CB'(1);
						rd_ok_q <= 1'b1;
						if (!valid_q[idx_q[SB-1:0]] && !free_ok_q) begin
							free_ok_q   <= 1'b1;
							free_slot_q <= idx_q[SB-1:0];
						end
					end
					if (rd_valid && rd_q.order_id == id_q && !hit_q) begin
						hit_q      <= 1'b1;
						hit_slot_q <= rd_idx_q;
						hit_data_q <= rd_q;
					end
					if (scan_end && !rd_ok_q) state_q <= S_ACT;
				end
				S_ACT: begin
					idx_q   <= '0;
					state_q <= S_BEST;
					gap_q   <= hit_data_q.arrival;
					priority case (kind_q)
						lob_pkg::KIND_ADD: begin
							if (hit_q) status_q <= lob_pkg::ST_DUPLICATE;
							else if (!free_ok_q) status_q <= lob_pkg::ST_FULL;
							else begin
								valid_q[free_slot_q] <= 1'b1;
								live_q <= live_q + CB'(1);
							end
						end
						lob_pkg::KIND_CANCEL, lob_pkg::KIND_MODIFY: begin
							if (!hit_q) status_q <= lob_pkg::ST_UNKNOWN;
							else if (kind_q == lob_pkg::KIND_MODIFY &&
									hit_data_q.price == px_q &&
									hit_data_q.side == side_q &&
									hit_data_q.quantity == qty_q)
								status_q <= lob_pkg::ST_UNCHANGED;
							else if (kind_q == lob_pkg::KIND_MODIFY &&
									hit_data_q.price == px_q &&
									hit_data_q.side == side_q &&
									hit_data_q.quantity < qty_q) begin
							end else begin
								valid_q[hit_slot_q] <= 1'b0;
								live_q  <= live_q - CB'(1);
								state_q <= S_SHIFT;
							end
						end
						lob_pkg::KIND_EXISTS:
							if (!hit_q) status_q <= lob_pkg::ST_UNKNOWN;
						default: ;
					endcase
				end
				S_SHIFT: begin
					if (!scan_end) begin
						idx_q   <= idx_q + CB'(1);
						rd_ok_q <= 1'b1;
					end
					if (scan_end && !rd_ok_q) begin
						idx_q   <= '0;
						state_q <= (kind_q == lob_pkg::KIND_MODIFY) ? S_PLACE : S_BEST;
					end
				end
				S_PLACE: begin
					valid_q[hit_slot_q] <= 1'b1;
					live_q  <= live_q + CB'(1);
					state_q <= S_BEST;
				end
				S_BEST: begin
					if (!scan_end) begin
						idx_q   <= idx_q + CB'(1);
						rd_ok_q <= 1'b1;
					end
					if (rd_valid) begin
						if (!rd_q.side) begin
							if (!hb_q || rd_q.price > b_q) begin
								b_q <= rd_q.price; hb_q <= 1'b1;
							end
						end else if (!ha_q || rd_q.price < a_q) begin
							a_q <= rd_q.price; ha_q <= 1'b1;
						end
					end
					if (scan_end && !rd_ok_q) begin
						if (kind_q == lob_pkg::KIND_LIST) begin
							// best prices known: walk ranks
							idx_q   <= '0;
							state_q <= S_LIST;
							rank_q  <= '0;
							kind_q  <= KIND_BEST_DONE;
						end else begin
							result_valid <= 1'b1;
							status       <= status_q;
							has_id       <= 1'b0;
							listed_id    <= '0;
							last         <= 1'b1;
							best_bid     <= hb_q ? {1'b0, 32'(b_q)} : '1;
							best_ask     <= ha_q ? {1'b0, 32'(a_q)} : '1;
							state_q      <= S_IDLE;
						end
					end
				end
				S_LIST: begin
					// first entry: need best prices first
					if (kind_q == lob_pkg::KIND_LIST) begin
						state_q <= S_BEST;
					end else if (rank_q == live_q) begin
						// flush held member (or empty marker) with last
						result_valid <= 1'b1;
						status       <= lob_pkg::ST_OK;
						has_id       <= pend_q;
						listed_id    <= pend_q ? pend_id_q : '0;
						last         <= 1'b1;
						best_bid     <= hb_q ? {1'b0, 32'(b_q)} : '1;
						best_ask     <= ha_q ? {1'b0, 32'(a_q)} : '1;
						pend_q       <= 1'b0;
						state_q      <= S_IDLE;
					end else begin
						if (!scan_end) begin
							idx_q   <= idx_q + CB'(1);
							rd_ok_q <= 1'b1;
						end
						if (rd_valid && rd_q.arrival == rank_q[SB-1:0] &&
								rd_q.side == side_q && rd_q.price == px_q) begin
							if (pend_q) begin
								result_valid <= 1'b1;
								status       <= lob_pkg::ST_OK;
								has_id       <= 1'b1;
								listed_id    <= pend_id_q;
								last         <= 1'b0;
								best_bid     <= hb_q ? {1'b0, 32'(b_q)} : '1;
								best_ask     <= ha_q ? {1'b0, 32'(a_q)} : '1;
							end
							pend_q    <= 1'b1;
							pend_id_q <= rd_q.order_id;
						end
						if (scan_end && !rd_ok_q) begin
							idx_q  <= '0;
							rank_q <= rank_q + CB'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule
`default_nettype wire

// ----- hdl/lob_checker.sv -----
// lob_checker: port-level assertions for limit_order_book, bound to the top level.
// Depends on lob_pkg and the limit_order_book ports.
`default_nettype none
module lob_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              result_valid,
	input wire logic              last,
	input wire logic              has_id,
	input wire logic [2:0]        status
);
	// a transaction accepted from idle makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	// the final result of a transaction comes with the block free
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy) else $error("busy at last");
	// a non-final result is always a listed member
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> has_id && status == lob_pkg::ST_OK)
		else $error("bad non-final result");
	// no result while idle before it
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result from idle");
endmodule

bind limit_order_book lob_checker u_lob_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.result_valid(result_valid), .last(last), .has_id(has_id), .status(status)
);
`default_nettype wire

// ----- bench/tb.sv -----
// tb: self-checking bench for limit_order_book. It holds a queue-driven command driver,
// a result monitor and a price-time book predictor.
// Depends on lob_pkg and limit_order_book.
`timescale 1ns / 100ps
module tb;
	// one pending command transaction
	typedef struct {
		logic [2:0]  kind;
		logic [63:0] oid;
		logic [31:0] px;
		logic [31:0] qty;
		logic        sd;
		bit          drain_first;  // hold off until every expected result is in
		bit          no_gap;       // tail of the run: no idling
	} cmd_t;

	// one expected result
	typedef struct {
		logic [2:0]         status;
		logic signed [32:0] bid;
		logic signed [32:0] ask;
		logic               has_id;
		logic [63:0]        lid;
		logic               last;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] kind = '0;
	logic [63:0] order_id = '0;
	logic [31:0] price = '0;
	logic [31:0] quantity = '0;
	logic side = 1'b0;
	wire busy, result_valid, has_id, last;
	wire [2:0] status;
	wire signed [32:0] best_bid, best_ask;
	wire [63:0] listed_id;

	cmd_t pend_cmds[$];
	res_t book_results[$];
	cmd_t cur;
	int gap_cnt = 0;
	int fails = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_lists = 0;

	// predictor copy of the book
	bit          bk_valid[lob_pkg::ORDER_CAPACITY];
	logic [63:0] bk_id[lob_pkg::ORDER_CAPACITY];
	logic [31:0] bk_px[lob_pkg::ORDER_CAPACITY];
	logic [31:0] bk_qty[lob_pkg::ORDER_CAPACITY];
	logic        bk_side[lob_pkg::ORDER_CAPACITY];
	int          bk_rank[lob_pkg::ORDER_CAPACITY];
	int          live_cnt = 0;

	limit_order_book DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .order_id(order_id), .price(price), .quantity(quantity), .side(side),
		.result_valid(result_valid), .status(status), .best_bid(best_bid),
		.best_ask(best_ask), .has_id(has_id), .listed_id(listed_id), .last(last)
	);

	always #5 clk = ~clk;

	function automatic int slot_of(logic [63:0] id);
		for (int i = 0; i < lob_pkg::ORDER_CAPACITY; i++)
			if (bk_valid[i] && bk_id[i] == id)
				return i;
		return -1;
	endfunction

	// an order leaving closes the gap in the arrival ranks
	function automatic void unlink_slot(int s);
		int r;
		r = bk_rank[s];
		bk_valid[s] = 0;
		for (int i = 0; i < lob_pkg::ORDER_CAPACITY; i++)
			if (bk_valid[i] && bk_rank[i] > r)
				bk_rank[i]--;
		if (live_cnt > 0)
			live_cnt--;
	endfunction

	function automatic void rest_order(int s, cmd_t c);
		bk_valid[s] = 1;
		bk_id[s] = c.oid;
		bk_px[s] = c.px;
		bk_qty[s] = c.qty;
		bk_side[s] = c.sd;
		bk_rank[s] = live_cnt;
		live_cnt++;
	endfunction

	function automatic res_t top_of_book(logic [2:0] st);
		res_t r;
		bit hb, ha;
		logic [31:0] b, a;
		hb = 0;
		ha = 0;
		b = '0;
		a = '0;
		for (int i = 0; i < lob_pkg::ORDER_CAPACITY; i++) begin
			if (!bk_valid[i])
				continue;
			if (bk_side[i] == 1'b0) begin
				if (!hb || bk_px[i] > b) begin
					b = bk_px[i];
					hb = 1;
				end
			end else begin
				if (!ha || bk_px[i] < a) begin
					a = bk_px[i];
					ha = 1;
				end
			end
		end
		r.status = st;
		r.bid = hb ? $signed({1'b0, b}) : -33'sd1;
		r.ask = ha ? $signed({1'b0, a}) : -33'sd1;
		r.has_id = 1'b0;
		r.lid = '0;
		r.last = 1'b1;
		return r;
	endfunction

	// apply one accepted command to the book and queue what it must produce
	function automatic void apply_to_book(cmd_t c);
		res_t r;
		logic [2:0] st;
		int s, n;
		st = lob_pkg::ST_OK;
		if (c.kind == lob_pkg::KIND_LIST) begin
			r = top_of_book(lob_pkg::ST_OK);
			n = 0;
			n_lists++;
			for (int rk = 0; rk < live_cnt; rk++)
				for (int i = 0; i < lob_pkg::ORDER_CAPACITY; i++)
					if (bk_valid[i] && bk_rank[i] == rk && bk_side[i] == c.sd &&
							bk_px[i] == c.px) begin
						r.has_id = 1'b1;
						r.lid = bk_id[i];
						r.last = 1'b0;
						book_results.insert(book_results.size(), r);
						n++;
						break;
					end
			if (n == 0) begin
				r.last = 1'b1;
				book_results.insert(book_results.size(), r);
			end else
				book_results[book_results.size()-1].last = 1'b1;
			return;
		end
		case (c.kind)
			lob_pkg::KIND_ADD: begin
				if (slot_of(c.oid) >= 0)
					st = lob_pkg::ST_DUPLICATE;
				else begin
					s = -1;
					for (int i = lob_pkg::ORDER_CAPACITY - 1; i >= 0; i--)
						if (!bk_valid[i])
							s = i;
					if (s < 0)
						st = lob_pkg::ST_FULL;
					else
						rest_order(s, c);
				end
			end
			lob_pkg::KIND_CANCEL: begin
				s = slot_of(c.oid);
				if (s < 0)
					st = lob_pkg::ST_UNKNOWN;
				else
					unlink_slot(s);
			end
			lob_pkg::KIND_MODIFY: begin
				s = slot_of(c.oid);
				if (s < 0)
					st = lob_pkg::ST_UNKNOWN;
				else if (bk_px[s] == c.px && bk_side[s] == c.sd && bk_qty[s] == c.qty)
					st = lob_pkg::ST_UNCHANGED;
				else if (bk_px[s] == c.px && bk_side[s] == c.sd && bk_qty[s] < c.qty)
					bk_qty[s] = c.qty;  // keeps queue position
				else begin
					unlink_slot(s);
					rest_order(s, c);
				end
			end
			lob_pkg::KIND_EXISTS:
				st = (slot_of(c.oid) >= 0) ? lob_pkg::ST_OK : lob_pkg::ST_UNKNOWN;
			default: ;
		endcase
		book_results.insert(book_results.size(), top_of_book(st));
	endfunction

	// driver: start stays up until the transaction is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				apply_to_book(cur);
				n_accepted++;
			end
			if (start && busy) begin
				// held: nothing changes
			end else if (gap_cnt > 0) begin
				gap_cnt <= gap_cnt - 1;
				start <= 1'b0;
			end else if (pend_cmds.size() != 0 &&
					!(pend_cmds[0].drain_first && book_results.size() != 0)) begin
				cur = pend_cmds.pop_front();
				kind <= cur.kind;
				order_id <= cur.oid;
				price <= cur.px;
				quantity <= cur.qty;
				side <= cur.sd;
				start <= 1'b1;
				if (!cur.no_gap && $urandom_range(0, 3) == 0)
					gap_cnt <= $urandom_range(1, 16);
			end else
				start <= 1'b0;
		end
	end

	// monitor: each strobed result is matched against the oldest expectation
	always @(posedge clk) begin
		res_t e;
		if (arst_n && result_valid) begin
			n_results++;
			if (book_results.size() == 0) begin
				$error("unexpected result: status %0d listed_id %h", status, listed_id);
				fails++;
			end else begin
				e = book_results.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					fails++;
				end
				if (best_bid !== e.bid) begin
					$error("best_bid: expected %0d, got %0d", e.bid, best_bid);
					fails++;
				end
				if (best_ask !== e.ask) begin
					$error("best_ask: expected %0d, got %0d", e.ask, best_ask);
					fails++;
				end
				if (has_id !== e.has_id) begin
					$error("has_id: expected %0d, got %0d", e.has_id, has_id);
					fails++;
				end
				if (listed_id !== e.lid) begin
					$error("listed_id: expected %h, got %h", e.lid, listed_id);
					fails++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, last);
					fails++;
				end
			end
		end
	end

	function automatic void queue_cmd(logic [2:0] k, logic [63:0] id, logic [31:0] px,
			logic [31:0] q, logic sd, bit drain = 0, bit tail = 0);
		cmd_t c;
		c.kind = k;
		c.oid = id;
		c.px = px;
		c.qty = q;
		c.sd = sd;
		c.drain_first = drain;
		c.no_gap = tail;
		pend_cmds.insert(pend_cmds.size(), c);
	endfunction

	// random traffic on a few crowded levels, with rare wide values
	function automatic void queue_mixed(int n, bit tail);
		int w;
		logic [2:0] k;
		logic [63:0] id;
		logic [31:0] px, q;
		for (int i = 0; i < n; i++) begin
			w = $urandom_range(0, 99);
			k = w < 35 ? lob_pkg::KIND_ADD : w < 55 ? lob_pkg::KIND_CANCEL :
				w < 75 ? lob_pkg::KIND_MODIFY : w < 87 ? lob_pkg::KIND_LIST :
				lob_pkg::KIND_EXISTS;
			id = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 30));
			w = $urandom_range(0, 19);
			px = w == 0 ? 32'hFFFF_FFFF : w == 1 ? 32'd0 : w < 4 ? $urandom :
				32'd1000 + $urandom_range(0, 4);
			q = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom;
			queue_cmd(k, id, px, q, $urandom_range(0, 1), 0, tail);
		end
	endfunction

	initial begin
		// directed: extremes and every special case of the book
		queue_cmd(lob_pkg::KIND_LIST, 0, 32'd1000, 0, 0);          // empty level, empty book
		queue_cmd(lob_pkg::KIND_ADD, 64'd0, 32'd0, 32'd0, 0);      // bid at 0, zero quantity
		queue_cmd(lob_pkg::KIND_ADD, '1, 32'hFFFF_FFFF, '1, 1);    // ask at top price
		queue_cmd(lob_pkg::KIND_ADD, 64'd0, 32'd5, 32'd1, 1);      // duplicate id
		queue_cmd(lob_pkg::KIND_EXISTS, '1, 0, 0, 0);
		queue_cmd(lob_pkg::KIND_EXISTS, 64'd77, 0, 0, 0);          // unknown
		queue_cmd(lob_pkg::KIND_CANCEL, 64'd77, 0, 0, 0);          // unknown
		queue_cmd(lob_pkg::KIND_MODIFY, 64'd77, 32'd1, 32'd1, 0);  // unknown
		queue_cmd(lob_pkg::KIND_ADD, 64'd1, 32'd1000, 32'd10, 0);
		queue_cmd(lob_pkg::KIND_ADD, 64'd2, 32'd1000, 32'd10, 0);
		queue_cmd(lob_pkg::KIND_ADD, 64'd3, 32'd1000, 32'd10, 0);
		queue_cmd(lob_pkg::KIND_MODIFY, 64'd2, 32'd1000, 32'd10, 0);  // identical
		queue_cmd(lob_pkg::KIND_MODIFY, 64'd1, 32'd1000, 32'd20, 0);  // larger: keeps place
		queue_cmd(lob_pkg::KIND_LIST, 0, 32'd1000, 0, 0);
		queue_cmd(lob_pkg::KIND_MODIFY, 64'd1, 32'd1000, 32'd5, 0);   // smaller: to the back
		queue_cmd(lob_pkg::KIND_LIST, 0, 32'd1000, 0, 0);
		queue_cmd(lob_pkg::KIND_MODIFY, 64'd2, 32'd1001, 32'd5, 0);   // price change
		queue_cmd(lob_pkg::KIND_MODIFY, 64'd3, 32'd1000, 32'd10, 1);  // side change
		queue_cmd(lob_pkg::KIND_LIST, 0, 32'd1000, 0, 0);
		queue_cmd(lob_pkg::KIND_CANCEL, 64'd0, 0, 0, 0);
		queue_cmd(lob_pkg::KIND_CANCEL, '1, 0, 0, 0);
		queue_cmd(lob_pkg::KIND_LIST, 0, 32'd1000, 0, 1);
		// random mix, then fill the book past capacity
		queue_mixed(66, 0);
		for (int i = 0; i < 70; i++)
			queue_cmd(lob_pkg::KIND_ADD, 64'd5000 + i, 32'd1000 + $urandom_range(0, 1),
				$urandom, $urandom_range(0, 1), i == 0);
		queue_cmd(lob_pkg::KIND_LIST, 0, 32'd1000, 0, 0);
		queue_cmd(lob_pkg::KIND_LIST, 0, 32'd1001, 0, 1);
		for (int i = 0; i < 20; i++)
			queue_cmd(lob_pkg::KIND_CANCEL, 64'd5000 + $urandom_range(0, 69), 0, 0, 0);
		queue_mixed(40, 0);
		queue_mixed(40, 1);  // tail without idling

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (pend_cmds.size() != 0 || start)
			@(posedge clk);
		while (book_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("%0d commands (%0d level lists) drove %0d results, book filled to capacity",
			n_accepted, n_lists, n_results);
		$display("adds, cancels, modifies in all forms, lookups and empty levels were covered");
		if (fails == 0 && book_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- sim.f -----
hdl/lob_pkg.sv
hdl/limit_order_book.sv
hdl/lob_checker.sv
bench/tb.sv
